@@ src/repeated_packet_filter_unit_macros.svh @@
// Assertion macros for the repeated packet filter.
// Included by the top level; no other dependencies.
`ifndef REPEATED_PACKET_FILTER_UNIT_MACROS_SVH
`define REPEATED_PACKET_FILTER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define RPF_ASSERT_IMP(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("rpf assertion failed");
`define RPF_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("rpf assertion failed");
`else
`define RPF_ASSERT_IMP(label, clk, rst, pre, post)
`define RPF_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

@@ src/rpf_pkg.sv @@
// Shared types, constants and the fold function of the repeated packet filter.
// No dependencies.
package rpf_pkg;

  localparam logic [31:0] SUM_INIT  = 32'h0000_FFFF;
  localparam logic [8:0]  BLOCK_LEN = 9'd359;
  localparam logic [7:0]  AGE_MAX   = 8'hFF;
  localparam logic [4:0]  CAP_RESET = 5'd16;

  typedef struct packed {
    logic [15:0] address;
    logic [7:0]  msg_ref;
    logic [31:0] sum;
    logic [7:0]  age;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic add_low;
    logic add_high;
    logic fold;
  } sum_cmd_t;

  function automatic logic [31:0] fold16(input logic [31:0] x);
    return {16'h0000, x[15:0]} + {16'h0000, x[31:16]};
  endfunction

endpackage

@@ src/rpf_if.sv @@
// Handshake channels of the repeated packet filter: payload words in, results out.
// No dependencies.
interface rpf_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] source_device;
  logic [7:0]  message_ref;
  logic [15:0] payload_word;
  logic        word_valid;
  logic        last_word;

  modport source (output valid, source_device, message_ref, payload_word, word_valid,
                  last_word, input ready);
  modport sink (input valid, source_device, message_ref, payload_word, word_valid,
                last_word, output ready);
endinterface

interface rpf_out_if;
  logic        valid;
  logic        ready;
  logic        is_repeat;
  logic [31:0] packet_checksum;
  logic        evicted;

  modport source (output valid, is_repeat, packet_checksum, evicted, input ready);
  modport sink (input valid, is_repeat, packet_checksum, evicted, output ready);
endinterface

@@ src/rpf_sum_unit.sv @@
// Fletcher-32 running sums with block folding and a block word count.
// Depends on rpf_pkg.
module rpf_sum_unit (
  input  logic             clk,
  input  logic             rst,
  input  rpf_pkg::sum_cmd_t cmd,
  input  logic [15:0]      word,
  output logic             block_full,
  output logic             block_open,
  output logic [31:0]      checksum
);
  import rpf_pkg::*;

  logic [31:0] run_sum_low;
  logic [31:0] run_sum_high;
  logic [8:0]  block_words;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      run_sum_low  <= SUM_INIT;
      run_sum_high <= SUM_INIT;
      block_words  <= '0;
    end else begin
      if (cmd.add_low) begin
        run_sum_low <= run_sum_low + {16'h0000, word};
        block_words <= block_words + 9'd1;
      end
      if (cmd.add_high) begin
        run_sum_high <= run_sum_high + run_sum_low;
      end
      if (cmd.fold) begin
        run_sum_low  <= fold16(run_sum_low);
        run_sum_high <= fold16(run_sum_high);
        block_words  <= '0;
      end
    end
  end

  assign block_full = (block_words >= BLOCK_LEN);
  assign block_open = (block_words != 9'd0);
  assign checksum   = {run_sum_high[15:0], run_sum_low[15:0]};

endmodule

@@ src/repeated_packet_filter_unit.sv @@
// Repeated packet filter: Fletcher-32 over payload words, then a table lookup per packet.
// Depends on rpf_pkg, rpf_if, rpf_sum_unit and repeated_packet_filter_unit_macros.svh.
//
// Usage:
//   words: one payload word per item, with source_device, message_ref, word_valid and
//     last_word. An item with word_valid 0 adds nothing; last_word closes the packet.
//   result: one item per packet (is_repeat, packet_checksum, evicted), none otherwise.
//   capacity_we/capacity_data: write the capacity register while the block is idle.
// Word handling: only S_IDLE takes an item. A counted word then passes S_ACC, and
//   S_FOLD too when it closes a 359-word block; a word with word_valid 0 that does not
//   close the packet stays in S_IDLE. The sums are updated in two steps.
//   After the last word no item is taken until the result register is loaded.
// Closing a packet: the folds of S_FIN1 (only when the block is open) and S_FIN2, a walk
//   over the table memory in S_SRCH (one read per cycle, registered read data), then
//   S_DECIDE updates the entry and loads the result register.
// Reset: clears the table valid bits, the fill count and the sums; capacity returns
//   to 16. No clearing pass is needed. No item is taken while reset is high.
// Stall: the result register holds until taken; words are still accepted meanwhile,
//   and the block waits only when a second packet result is ready before the first
//   has been taken.
`include "repeated_packet_filter_unit_macros.svh"
module repeated_packet_filter_unit #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  rpf_in_if.sink       words,
  rpf_out_if.source    result,
  input  logic         capacity_we,
  input  logic [4:0]   capacity_data
);
  import rpf_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W = ((CNT_W > 5) ? CNT_W : 5) + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_ACC, S_FOLD, S_FIN1, S_FIN2, S_SRCH, S_DECIDE
  } state_t;

  state_t             state;
  logic [4:0]         capacity;
  logic [15:0]        dev;
  logic [7:0]         msg_ref;
  logic               last_q;

  entry_t             mem [TABLE_DEPTH];
  entry_t             rdata;
  logic               rvalid;
  logic [IDX_W-1:0]   ridx;
  logic               rd_pend;
  logic [CNT_W-1:0]   rd_cnt;
  logic [TABLE_DEPTH-1:0] slot_valid;
  logic [TABLE_DEPTH-1:0] slot_valid_next;
  logic [CNT_W-1:0]   slot_count;

  logic               hit_found;
  logic [IDX_W-1:0]   hit_idx;
  entry_t             hit_entry;
  logic               vic_found;
  logic [IDX_W-1:0]   vic_idx;
  logic [7:0]         vic_age;
  logic [15:0]        vic_addr;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;

  sum_cmd_t           cmd;
  logic               block_full;
  logic               block_open;
  logic [31:0]        checksum;

  logic               accept;
  logic               go;
  logic               take_hit;
  logic               take_vic;
  logic               take_free;
  logic               repeat_hit;
  logic               full;
  logic               evict;
  logic [IDX_W-1:0]   ins_idx;
  logic [CMP_W-1:0]   cap_ext;
  logic [CMP_W-1:0]   eff_cap;
  logic               mem_we;
  logic [IDX_W-1:0]   wr_idx;
  entry_t             wr_entry;

  rpf_sum_unit u_sum (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .word       (words.payload_word),
    .block_full (block_full),
    .block_open (block_open),
    .checksum   (checksum)
  );

  assign words.ready = (state == S_IDLE) && !rst;
  assign accept      = words.valid && words.ready;
  assign go          = (state == S_DECIDE) && (!result.valid || result.ready);

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE:   cmd.add_low = accept && words.word_valid;
      S_ACC:    cmd.add_high = 1'b1;
      S_FOLD:   cmd.fold = 1'b1;
      S_FIN1:   cmd.fold = block_open;
      S_FIN2:   cmd.fold = 1'b1;
      S_DECIDE: cmd.clear = go;
      default:  cmd = '0;
    endcase
  end

  assign take_hit  = rd_pend && rvalid && (rdata.address == dev) && !hit_found;
  assign take_vic  = rd_pend && rvalid &&
                     (!vic_found || (rdata.age < vic_age) ||
                      ((rdata.age == vic_age) && (rdata.address < vic_addr)));
  assign take_free = rd_pend && !rvalid && !free_found;

  assign cap_ext = CMP_W'(capacity);
  always_comb begin
    if (capacity == 5'd0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(TABLE_DEPTH)) begin
      eff_cap = CMP_W'(TABLE_DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
  end
  assign full       = (CMP_W'(slot_count) >= eff_cap);
  assign repeat_hit = hit_found && (hit_entry.msg_ref == msg_ref) &&
                      (hit_entry.sum == checksum);
  assign evict      = !hit_found && full && vic_found;
  assign ins_idx    = (evict && (!free_found || (vic_idx < free_idx))) ? vic_idx : free_idx;

  always_comb begin
    slot_valid_next = slot_valid;
    if (evict) begin
      slot_valid_next[vic_idx] = 1'b0;
    end
    slot_valid_next[ins_idx] = 1'b1;
  end

  always_comb begin
    mem_we   = 1'b0;
    wr_idx   = ins_idx;
    wr_entry = '{address: dev, msg_ref: msg_ref, sum: checksum, age: 8'd0};
    if (go) begin
      if (hit_found) begin
        mem_we        = !repeat_hit;
        wr_idx        = hit_idx;
        wr_entry.age  = (hit_entry.age == AGE_MAX) ? AGE_MAX : hit_entry.age + 8'd1;
      end else begin
        mem_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx] <= wr_entry;
    end
    rdata  <= mem[rd_cnt[IDX_W-1:0]];
    rvalid <= slot_valid[rd_cnt[IDX_W-1:0]];
    ridx   <= rd_cnt[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      capacity     <= CAP_RESET;
      rd_pend      <= 1'b0;
      rd_cnt       <= '0;
      slot_valid   <= '0;
      slot_count   <= '0;
      hit_found    <= 1'b0;
      vic_found    <= 1'b0;
      free_found   <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (capacity_we) begin
        capacity <= capacity_data;
      end
      if (go) begin
        result.valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      rd_pend <= (state == S_SRCH) && (rd_cnt != CNT_W'(TABLE_DEPTH));

      if (take_hit) begin
        hit_found <= 1'b1;
        hit_idx   <= ridx;
        hit_entry <= rdata;
      end
      if (take_vic) begin
        vic_found <= 1'b1;
        vic_idx   <= ridx;
        vic_age   <= rdata.age;
        vic_addr  <= rdata.address;
      end
      if (take_free) begin
        free_found <= 1'b1;
        free_idx   <= ridx;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            dev     <= words.source_device;
            msg_ref <= words.message_ref;
            last_q  <= words.last_word;
            if (words.word_valid) begin
              state <= S_ACC;
            end else if (words.last_word) begin
              state <= S_FIN1;
            end
          end
        end
        S_ACC: begin
          if (block_full) begin
            state <= S_FOLD;
          end else begin
            state <= last_q ? S_FIN1 : S_IDLE;
          end
        end
        S_FOLD: begin
          state <= last_q ? S_FIN1 : S_IDLE;
        end
        S_FIN1: begin
          state <= S_FIN2;
        end
        S_FIN2: begin
          rd_cnt     <= '0;
          hit_found  <= 1'b0;
          vic_found  <= 1'b0;
          free_found <= 1'b0;
          state      <= S_SRCH;
        end
        S_SRCH: begin
          // walk the table one entry per cycle; the last read lands as we leave
          if (rd_cnt == CNT_W'(TABLE_DEPTH)) begin
            state <= S_DECIDE;
          end else begin
            rd_cnt <= rd_cnt + CNT_W'(1);
          end
        end
        S_DECIDE: begin
          if (go) begin
            if (!hit_found) begin
              slot_valid <= slot_valid_next;
              if (!evict) begin
                slot_count <= slot_count + CNT_W'(1);
              end
            end
            result.is_repeat       <= repeat_hit;
            result.packet_checksum <= checksum;
            result.evicted         <= evict;
            state                  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `RPF_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, (CMP_W'(slot_count) <= CMP_W'(TABLE_DEPTH)))
  `RPF_ASSERT_IMP(a_count_match, clk, rst, 1'b1, ($countones(slot_valid) == int'(slot_count)))
  `RPF_ASSERT_IMP(a_room_found, clk, rst, (go && !hit_found), (free_found || evict))
  `RPF_ASSERT_NEXT(a_result_loaded, clk, rst, go, result.valid)

endmodule

@@ dv/rpf_filter_checker.sv @@
`timescale 1ns / 100ps
// Checker for the repeated packet filter: predicts the packet results from the accepted
// words and compares them with the result channel. Depends on rpf_pkg and rpf_if.
module rpf_filter_checker (
  input  logic       clk,
  input  logic       rst,
  rpf_in_if          words,
  rpf_out_if         result,
  input  logic       capacity_we,
  input  logic [4:0] capacity_data,
  output int         mismatches,
  output int         outstanding
);
  import rpf_pkg::*;

  localparam int TABLE_SLOTS = 16;

  typedef struct packed {
    logic        is_repeat;
    logic [31:0] checksum;
    logic        evicted;
  } pkt_result_t;

  entry_t      slots [TABLE_SLOTS];
  logic        slot_live [TABLE_SLOTS];
  int          fill;
  logic [31:0] acc_low;
  logic [31:0] acc_high;
  int          blk_words;
  logic [4:0]  cap_reg;
  int          err_count;
  pkt_result_t expected_results [$];

  function automatic logic [31:0] fold_half(input logic [31:0] x);
    return (x & 32'h0000_FFFF) + (x >> 16);
  endfunction

  task automatic filter_word(input logic [15:0] dev, input logic [7:0] mref,
                             input logic [15:0] w, input logic wv, input logic last);
    int i;
    int hit;
    int victim;
    int free_slot;
    int limit;
    logic [31:0] chk;
    pkt_result_t r;
    if (wv) begin
      acc_low = acc_low + {16'h0000, w};
      acc_high = acc_high + acc_low;
      blk_words++;
      if (blk_words >= BLOCK_LEN) begin
        acc_low = fold_half(acc_low);
        acc_high = fold_half(acc_high);
        blk_words = 0;
      end
    end
    if (!last) return;
    if (blk_words != 0) begin
      acc_low = fold_half(acc_low);
      acc_high = fold_half(acc_high);
    end
    acc_low = fold_half(acc_low);
    acc_high = fold_half(acc_high);
    chk = {acc_high[15:0], acc_low[15:0]};
    r = '{is_repeat: 1'b0, checksum: chk, evicted: 1'b0};
    hit = -1;
    for (i = 0; i < TABLE_SLOTS; i++) begin
      if (hit < 0 && slot_live[i] && slots[i].address == dev) hit = i;
    end
    if (hit >= 0) begin
      if (slots[hit].msg_ref != mref || slots[hit].sum != chk) begin
        if (slots[hit].age != AGE_MAX) slots[hit].age = slots[hit].age + 8'd1;
        slots[hit].msg_ref = mref;
        slots[hit].sum = chk;
      end else begin
        r.is_repeat = 1'b1;
      end
    end else begin
      limit = (cap_reg == 0) ? 1 : ((cap_reg > TABLE_SLOTS) ? TABLE_SLOTS : int'(cap_reg));
      if (fill >= limit) begin
        victim = -1;
        for (i = 0; i < TABLE_SLOTS; i++) begin
          if (slot_live[i]) begin
            if (victim < 0 || slots[i].age < slots[victim].age ||
                (slots[i].age == slots[victim].age &&
                 slots[i].address < slots[victim].address))
              victim = i;
          end
        end
        if (victim >= 0) begin
          slot_live[victim] = 1'b0;
          fill--;
          r.evicted = 1'b1;
        end
      end
      free_slot = -1;
      for (i = 0; i < TABLE_SLOTS; i++) begin
        if (free_slot < 0 && !slot_live[i]) free_slot = i;
      end
      if (free_slot >= 0) begin
        slot_live[free_slot] = 1'b1;
        slots[free_slot] = '{address: dev, msg_ref: mref, sum: chk, age: 8'd0};
        fill++;
      end
    end
    acc_low = SUM_INIT;
    acc_high = SUM_INIT;
    blk_words = 0;
    expected_results = {expected_results, r};
  endtask

  always @(posedge clk) begin
    pkt_result_t got;
    pkt_result_t want;
    if (rst) begin
      for (int i = 0; i < TABLE_SLOTS; i++) slot_live[i] = 1'b0;
      fill = 0;
      acc_low = SUM_INIT;
      acc_high = SUM_INIT;
      blk_words = 0;
      cap_reg = CAP_RESET;
      err_count = 0;
      expected_results.delete();
    end else begin
      if (capacity_we) cap_reg = capacity_data;
      if (words.valid && words.ready)
        filter_word(words.source_device, words.message_ref, words.payload_word,
                    words.word_valid, words.last_word);
      if (result.valid && result.ready) begin
        got = '{is_repeat: result.is_repeat, checksum: result.packet_checksum,
                evicted: result.evicted};
        if (expected_results.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("%t: unexpected result repeat=%0b sum=%08h evicted=%0b", $realtime,
                     got.is_repeat, got.checksum, got.evicted);
        end else begin
          want = expected_results.pop_front();
          if (got.is_repeat !== want.is_repeat || got.checksum !== want.checksum ||
              got.evicted !== want.evicted) begin
            err_count++;
            if (err_count <= 10)
              $display("%t: mismatch expected repeat=%0b sum=%08h evicted=%0b, got %0b %08h %0b",
                       $realtime, want.is_repeat, want.checksum, want.evicted,
                       got.is_repeat, got.checksum, got.evicted);
          end
        end
      end
    end
    mismatches <= err_count;
    outstanding <= expected_results.size();
  end

endmodule

@@ dv/repeated_packet_filter_unit_test.sv @@
`timescale 1ns / 100ps
// Top of the repeated packet filter testbench: clock, reset, word stimulus, capacity
// settings and result stalls. Depends on rpf_if, repeated_packet_filter_unit and rpf_filter_checker.
module repeated_packet_filter_unit_test;

  typedef struct packed {
    logic [15:0]      dev;
    logic [7:0]       mref;
    logic [3:0]       len;
    logic [7:0][15:0] w;
    logic [7:0]       wv;
  } packet_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       capacity_we;
  logic [4:0] capacity_data;
  logic       take_ready = 1'b0;
  int         mismatches;
  int         outstanding;
  int         burst_left = 0;
  bit         steady = 1'b0;
  int         stall_mode = 0;
  int         mode_left = 0;
  logic [15:0] dev_pool [24];
  packet_t    sent_log [$];

  rpf_in_if  words();
  rpf_out_if result();

  assign result.ready = take_ready;

  repeated_packet_filter_unit #(.TABLE_DEPTH(16)) uut (
    .clk           (clk),
    .rst           (rst),
    .words         (words),
    .result        (result),
    .capacity_we   (capacity_we),
    .capacity_data (capacity_data)
  );

  rpf_filter_checker filter_check (
    .clk           (clk),
    .rst           (rst),
    .words         (words),
    .result        (result),
    .capacity_we   (capacity_we),
    .capacity_data (capacity_data),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      mode_left <= $urandom_range(20, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: take_ready <= 1'b1;
      1: take_ready <= 1'($urandom_range(0, 1));
      default: take_ready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  task automatic push_item(input logic [15:0] dev, input logic [7:0] mref,
                           input logic [15:0] w, input logic wv, input logic last);
    if (!steady && burst_left == 0) begin
      words.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    words.valid <= 1'b1;
    words.source_device <= dev;
    words.message_ref <= mref;
    words.payload_word <= w;
    words.word_valid <= wv;
    words.last_word <= last;
    @(posedge clk);
    while (!words.ready) @(posedge clk);
  endtask

  task automatic send_packet(input packet_t p, input bit noisy);
    int n;
    int i;
    logic [15:0] d;
    logic [7:0] r;
    n = (p.len == 0) ? 1 : int'(p.len);
    for (i = 0; i < n; i++) begin
      d = p.dev;
      r = p.mref;
      if (noisy && i < n - 1) begin
        d = 16'($urandom);
        r = 8'($urandom);
      end
      if (p.len == 0) push_item(d, r, 16'($urandom), 1'b0, 1'b1);
      else push_item(d, r, p.w[i], p.wv[i], i == n - 1);
    end
    sent_log = {sent_log, p};
    if (sent_log.size() > 16) void'(sent_log.pop_front());
  endtask

  task automatic send_long(input logic [15:0] dev, input logic [7:0] mref, input int n,
                           input bit saturate);
    int i;
    for (i = 0; i < n; i++)
      push_item(dev, mref, saturate ? 16'hFFFF : 16'($urandom), 1'b1, i == n - 1);
  endtask

  function automatic packet_t make_packet(input int span);
    packet_t p;
    int i;
    p.dev = dev_pool[$urandom_range(0, span - 1)];
    p.mref = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 1)) : 8'($urandom);
    p.len = ($urandom_range(0, 9) == 0) ? 4'd0 : 4'($urandom_range(1, 8));
    for (i = 0; i < 8; i++) begin
      case ($urandom_range(0, 19))
        0, 1, 2: p.w[i] = 16'hFFFF;
        3, 4:    p.w[i] = 16'h0000;
        default: p.w[i] = 16'($urandom);
      endcase
      p.wv[i] = ($urandom_range(0, 11) != 0);
    end
    return p;
  endfunction

  task automatic settle();
    words.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [4:0] value);
    capacity_we <= 1'b1;
    capacity_data <= value;
    @(posedge clk);
    capacity_we <= 1'b0;
  endtask

  initial begin
    logic [4:0] cap_plan [9];
    packet_t p;
    int ph;
    int k;
    int span;
    int eff;
    cap_plan = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd16, 5'd2, 5'd17, 5'd8};
    rst <= 1'b1;
    capacity_we <= 1'b0;
    capacity_data <= 5'd0;
    words.valid <= 1'b0;
    words.source_device <= 16'h0000;
    words.message_ref <= 8'h00;
    words.payload_word <= 16'h0000;
    words.word_valid <= 1'b0;
    words.last_word <= 1'b0;
    for (k = 0; k < 24; k++) dev_pool[k] = 16'($urandom);
    dev_pool[0] = 16'h0000;
    dev_pool[1] = 16'hFFFF;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty packet, extremes, repeat, reference change, skipped words
    push_item(16'h0000, 8'h00, 16'hA5A5, 1'b0, 1'b1);
    push_item(16'hFFFF, 8'hFF, 16'h0000, 1'b1, 1'b1);
    push_item(16'hFFFF, 8'hFF, 16'h0000, 1'b1, 1'b1);
    push_item(16'hFFFF, 8'hFF, 16'hFFFF, 1'b1, 1'b1);
    push_item(16'hFFFF, 8'h00, 16'hFFFF, 1'b1, 1'b1);
    push_item(16'h1234, 8'h5A, 16'hFFFF, 1'b1, 1'b0);
    push_item(16'h1234, 8'h5A, 16'hABCD, 1'b0, 1'b0);
    push_item(16'h1234, 8'h5A, 16'hFFFF, 1'b1, 1'b1);
    push_item(16'h8001, 8'h80, 16'h8001, 1'b1, 1'b0);
    push_item(16'h8001, 8'h80, 16'h7FFE, 1'b0, 1'b1);
    push_item(16'h0000, 8'h00, 16'h5A5A, 1'b0, 1'b1);

    for (ph = 0; ph < 9; ph++) begin
      settle();
      write_capacity(cap_plan[ph]);
      eff = (cap_plan[ph] == 0) ? 1 : ((cap_plan[ph] > 16) ? 16 : int'(cap_plan[ph]));
      span = eff + $urandom_range(1, 4);
      if (span > 24) span = 24;
      steady = ($urandom_range(0, 3) == 0);
      if (ph == 0) begin
        send_long(dev_pool[2], 8'h11, 359, 1'b1);
        send_long(dev_pool[3], 8'h22, 361, 1'b0);
      end
      if (ph == 5) begin
        for (k = 0; k < 257; k++) push_item(dev_pool[4], k[7:0], 16'($urandom), 1'b0, 1'b1);
      end
      for (k = 0; k < 3; k++) begin
        if (sent_log.size() > 0 && $urandom_range(0, 99) < 35) begin
          send_packet(sent_log[$urandom_range(0, sent_log.size() - 1)], 1'b0);
        end else begin
          p = make_packet(span);
          send_packet(p, $urandom_range(0, 9) == 0);
        end
      end
    end

    words.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
